// ----- sv/assert_macros.svh -----
// assertion macros shared by the scheduler rtl
// no dependencies; clock i_clk and reset i_rst_n are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock outside reset
`define CHK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same check, also active during reset
`define CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/fpts_pkg.sv -----
// package for the fixed priority task scheduler
// types, action codes and helpers shared by controller, datapath and top level
`timescale 1ns / 1ps

package fpts_pkg;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_DELAY   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_REL,
        ST_SEL,
        ST_RUN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic cap;
        logic do_op;
        logic do_rel;
        logic do_sel;
        logic do_run;
        logic idx_first;
        logic idx_next;
        logic idx_sel;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic last;
        logic out_free;
    } t_sts;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        logic [15:0] r;
        r = (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

endpackage

// ----- sv/fixed_priority_task_scheduler_unit.sv -----
// channel   signals                           payload
// in        i_in_valid / o_in_ready          action, slot, priority_req, period, budget,
//                                             deadline, hard, extra_ticks
// out       o_out_valid / i_out_ready        running and timing fields, switch and busy totals
//
// a tick request goes through the accept cycle, the release scan and the priority scan at one
// slot a cycle each, the run step and the load of the output register
// load, release and delay requests go through accept, one table update and the output load
// synchronous active-low reset clears slot enables, jobs, time and counters
// a held result stalls the block only in its final cycle; input is taken again once
// the output register frees
// depends on fpts_pkg, fpts_ctrl, fpts_datapath and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_priority_task_scheduler_unit import fpts_pkg::*; #(
    parameter int SLOT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_slot,
    input  logic [7:0]  i_priority_req,
    input  logic [15:0] i_period,
    input  logic [15:0] i_budget,
    input  logic [15:0] i_deadline,
    input  logic        i_hard,
    input  logic [15:0] i_extra_ticks,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_running_valid,
    output logic [2:0]  o_running_slot,
    output logic        o_switched,
    output logic        o_preempted,
    output logic        o_started,
    output logic        o_finished,
    output logic [15:0] o_response_ticks,
    output logic [15:0] o_execution_ticks,
    output logic        o_deadline_missed,
    output logic        o_hard_failure,
    output logic [31:0] o_switch_total,
    output logic [31:0] o_busy_total
);

    t_cmd cmd;
    t_sts sts;

    fpts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fpts_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_action),
        .i_slot            (i_slot),
        .i_priority_req    (i_priority_req),
        .i_period          (i_period),
        .i_budget          (i_budget),
        .i_deadline        (i_deadline),
        .i_hard            (i_hard),
        .i_extra_ticks     (i_extra_ticks),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_running_valid   (o_running_valid),
        .o_running_slot    (o_running_slot),
        .o_switched        (o_switched),
        .o_preempted       (o_preempted),
        .o_started         (o_started),
        .o_finished        (o_finished),
        .o_response_ticks  (o_response_ticks),
        .o_execution_ticks (o_execution_ticks),
        .o_deadline_missed (o_deadline_missed),
        .o_hard_failure    (o_hard_failure),
        .o_switch_total    (o_switch_total),
        .o_busy_total      (o_busy_total)
    );

    `CHK_PROP(a_one_at_a_time, (i_in_valid && o_in_ready) |=> !o_in_ready, "accept while busy")
    `CHK_PROP(a_hard_needs_miss, (o_out_valid && o_hard_failure) |-> o_deadline_missed, "hard no miss")
    `CHK_PROP(a_idle_result, (o_out_valid && !o_running_valid) |-> (!o_switched && !o_started && !o_finished), "idle flags")
    `CHK_PROP(a_miss_on_finish, (o_out_valid && o_deadline_missed) |-> o_finished, "miss no finish")

endmodule

// ----- sv/fpts_ctrl.sv -----
// controller for the fixed priority task scheduler
// sequences accept, table update, release scan, select scan, run step and output load; uses fpts_pkg
`timescale 1ns / 1ps

module fpts_ctrl import fpts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = i_sts.is_tick ? ST_REL : ST_OP;
            end
            ST_OP:  n_state = ST_OUT;
            ST_REL: begin
                if (i_sts.last) n_state = ST_SEL;
            end
            ST_SEL: begin
                if (i_sts.last) n_state = ST_RUN;
            end
            ST_RUN: n_state = ST_OUT;
            ST_OUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            ST_OP:  o_cmd.do_op = 1'b1;
            ST_REL: begin
                o_cmd.do_rel    = 1'b1;
                o_cmd.idx_first = i_sts.last;
                o_cmd.idx_next  = !i_sts.last;
            end
            ST_SEL: begin
                o_cmd.do_sel   = 1'b1;
                o_cmd.idx_sel  = i_sts.last;
                o_cmd.idx_next = !i_sts.last;
            end
            ST_RUN: o_cmd.do_run = 1'b1;
            ST_OUT: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- sv/fpts_datapath.sv -----
// datapath for the fixed priority task scheduler
// slot table, time and counters, selection registers and output register; uses fpts_pkg
`timescale 1ns / 1ps

module fpts_datapath import fpts_pkg::*; #(
    parameter int SLOT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_slot,
    input  logic [7:0]  i_priority_req,
    input  logic [15:0] i_period,
    input  logic [15:0] i_budget,
    input  logic [15:0] i_deadline,
    input  logic        i_hard,
    input  logic [15:0] i_extra_ticks,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_running_valid,
    output logic [2:0]  o_running_slot,
    output logic        o_switched,
    output logic        o_preempted,
    output logic        o_started,
    output logic        o_finished,
    output logic [15:0] o_response_ticks,
    output logic [15:0] o_execution_ticks,
    output logic        o_deadline_missed,
    output logic        o_hard_failure,
    output logic [31:0] o_switch_total,
    output logic [31:0] o_busy_total
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // slot table
    logic [7:0]  r_prio     [SLOT_COUNT];
    logic [15:0] r_period   [SLOT_COUNT];
    logic [15:0] r_budget   [SLOT_COUNT];
    logic [15:0] r_deadline [SLOT_COUNT];
    logic        r_hardf    [SLOT_COUNT];
    logic [31:0] r_nrel     [SLOT_COUNT];
    logic [16:0] r_rem      [SLOT_COUNT];
    logic [31:0] r_ready_t  [SLOT_COUNT];
    logic [31:0] r_start_t  [SLOT_COUNT];
    logic [15:0] r_miss     [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_en, r_act, r_started;

    logic [31:0] r_time, r_sw_cnt, r_busy_cnt;
    logic        r_cur_valid;
    logic [IW-1:0] r_cur_slot;

    // captured request
    logic [1:0]  r_action;
    logic        r_in_range;
    logic [7:0]  r_prio_in;
    logic [15:0] r_period_in, r_budget_in, r_deadline_in, r_extra_in;
    logic        r_hard_in;

    logic [IW-1:0] r_idx, r_sel;
    logic          r_found;
    logic [7:0]    r_best;

    // staged result
    logic        r_s_valid, r_s_sw, r_s_pre, r_s_st, r_s_fin, r_s_miss, r_s_hfail;
    logic [15:0] r_s_resp, r_s_exec;

    // values at the scan index
    logic        en_i, act_i, started_i;
    logic [32:0] nrel_sum;
    logic [17:0] rem_sum;
    logic [31:0] start_eff, total_t, exec_t, resp_t;
    logic        rel_hit, sel_hit, run_fin, run_sw, run_miss;

    assign en_i      = r_en[r_idx];
    assign act_i     = r_act[r_idx];
    assign started_i = r_started[r_idx];
    assign nrel_sum  = {1'b0, r_nrel[r_idx]} + {17'b0, r_period[r_idx]};
    assign rem_sum   = {1'b0, r_rem[r_idx]} + {2'b0, r_extra_in};
    assign rel_hit   = en_i && (r_period[r_idx] != 16'd0) && (r_time == r_nrel[r_idx]);
    assign sel_hit   = en_i && act_i && (!r_found || (r_prio[r_idx] > r_best));
    assign start_eff = started_i ? r_start_t[r_idx] : r_time;
    assign total_t   = r_time - r_ready_t[r_idx];
    assign exec_t    = r_time - start_eff;
    assign resp_t    = start_eff - r_ready_t[r_idx];
    assign run_fin   = (r_rem[r_idx] <= 17'd1);
    assign run_sw    = !r_cur_valid || (r_cur_slot != r_idx);
    assign run_miss  = total_t > {16'b0, r_deadline[r_idx]};

    assign o_sts.is_tick  = (i_action == ACT_TICK);
    assign o_sts.last     = (r_idx == IW'(SLOT_COUNT - 1));
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // capture, index and selection registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_action      <= i_action;
            r_in_range    <= (32'(i_slot) < 32'(SLOT_COUNT));
            r_prio_in     <= i_priority_req;
            r_period_in   <= i_period;
            r_budget_in   <= i_budget;
            r_deadline_in <= i_deadline;
            r_hard_in     <= i_hard;
            r_extra_in    <= i_extra_ticks;
            r_idx         <= (i_action == ACT_TICK) ? '0 : IW'(i_slot);
            r_found       <= 1'b0;
            // running slot reads zero unless the scan finds one
            r_sel         <= '0;
        end else if (i_cmd.idx_first) begin
            r_idx <= '0;
        end else if (i_cmd.idx_next) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.idx_sel) begin
            r_idx <= sel_hit ? r_idx : r_sel;
        end
        if (i_cmd.do_sel && sel_hit) begin
            r_sel   <= r_idx;
            r_best  <= r_prio[r_idx];
            r_found <= 1'b1;
        end
    end

    // slot table payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_op && r_in_range) begin
            unique case (r_action)
                ACT_LOAD: begin
                    r_prio[r_idx]     <= r_prio_in;
                    r_period[r_idx]   <= r_period_in;
                    r_budget[r_idx]   <= r_budget_in;
                    r_deadline[r_idx] <= r_deadline_in;
                    r_hardf[r_idx]    <= r_hard_in;
                    r_nrel[r_idx]     <= r_time;
                    r_rem[r_idx]      <= '0;
                    r_ready_t[r_idx]  <= '0;
                    r_start_t[r_idx]  <= '0;
                    r_miss[r_idx]     <= '0;
                end
                ACT_RELEASE: begin
                    if (en_i && !act_i) begin
                        r_rem[r_idx]     <= {1'b0, r_budget[r_idx]};
                        r_ready_t[r_idx] <= r_time;
                    end
                end
                ACT_DELAY: begin
                    if (en_i && act_i) begin
                        r_rem[r_idx] <= rem_sum[17] ? 17'h1FFFF : rem_sum[16:0];
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.do_rel && rel_hit) begin
            if (!act_i) begin
                r_rem[r_idx]     <= {1'b0, r_budget[r_idx]};
                r_ready_t[r_idx] <= r_time;
            end
            r_nrel[r_idx] <= nrel_sum[32] ? 32'hFFFF_FFFF : nrel_sum[31:0];
        end
        if (i_cmd.do_run && r_found) begin
            if (!started_i) r_start_t[r_idx] <= r_time;
            if (run_fin) begin
                r_rem[r_idx] <= '0;
                if (run_miss && r_miss[r_idx] != 16'hFFFF) r_miss[r_idx] <= r_miss[r_idx] + 1'b1;
            end else begin
                r_rem[r_idx] <= r_rem[r_idx] - 1'b1;
            end
        end
    end

    // control state of slots, time and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= '0;
            r_act       <= '0;
            r_started   <= '0;
            r_time      <= '0;
            r_sw_cnt    <= '0;
            r_busy_cnt  <= '0;
            r_cur_valid <= 1'b0;
            r_cur_slot  <= '0;
        end else begin
            if (i_cmd.do_op && r_in_range) begin
                unique case (r_action)
                    ACT_LOAD: begin
                        r_en[r_idx]      <= 1'b1;
                        r_act[r_idx]     <= 1'b0;
                        r_started[r_idx] <= 1'b0;
                        if (r_cur_valid && r_cur_slot == r_idx) r_cur_valid <= 1'b0;
                    end
                    ACT_RELEASE: begin
                        if (en_i && !act_i) begin
                            r_act[r_idx]     <= 1'b1;
                            r_started[r_idx] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.do_rel && rel_hit && !act_i) begin
                r_act[r_idx]     <= 1'b1;
                r_started[r_idx] <= 1'b0;
            end
            if (i_cmd.do_run) begin
                if (r_found) begin
                    if (run_sw) r_sw_cnt <= r_sw_cnt + 1'b1;
                    r_busy_cnt       <= r_busy_cnt + 1'b1;
                    r_started[r_idx] <= 1'b1;
                    r_cur_slot       <= r_idx;
                    r_cur_valid      <= !run_fin;
                    if (run_fin) r_act[r_idx] <= 1'b0;
                end
                if (r_time != 32'hFFFF_FFFF) r_time <= r_time + 1'b1;
            end
        end
    end

    // staged result of the current request
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_op || (i_cmd.do_run && !r_found)) begin
            r_s_valid <= 1'b0;
            r_s_sw    <= 1'b0;
            r_s_pre   <= 1'b0;
            r_s_st    <= 1'b0;
            r_s_fin   <= 1'b0;
            r_s_miss  <= 1'b0;
            r_s_hfail <= 1'b0;
            r_s_resp  <= '0;
            r_s_exec  <= '0;
        end else if (i_cmd.do_run) begin
            r_s_valid <= 1'b1;
            r_s_sw    <= run_sw;
            r_s_pre   <= run_sw && r_cur_valid && r_act[r_cur_slot];
            r_s_st    <= !started_i;
            r_s_fin   <= run_fin;
            r_s_miss  <= run_fin && run_miss;
            r_s_hfail <= run_fin && run_miss && r_hardf[r_idx];
            r_s_resp  <= (!started_i || run_fin) ? sat16(resp_t) : 16'd0;
            r_s_exec  <= run_fin ? sat16(exec_t) : 16'd0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_running_valid   <= r_s_valid;
            o_running_slot    <= 3'(r_sel);
            o_switched        <= r_s_sw;
            o_preempted       <= r_s_pre;
            o_started         <= r_s_st;
            o_finished        <= r_s_fin;
            o_response_ticks  <= r_s_resp;
            o_execution_ticks <= r_s_exec;
            o_deadline_missed <= r_s_miss;
            o_hard_failure    <= r_s_hfail;
            o_switch_total    <= r_sw_cnt;
            o_busy_total      <= r_busy_cnt;
        end
    end

endmodule
